// ===== hdl/gibs_pkg.sv =====
package gibs_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_KEPT_DEF   = 64;
	localparam int COORD_BITS_DEF = 12;

	// Fixed field widths of the ports
	localparam int FIELD_W = 12;
	localparam int THR_W   = 16;
	localparam int POS_W   = 6;

	// Threshold after reset: 0.5 as a fraction over 65536
	localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

	typedef struct packed {
		logic [FIELD_W-1:0] left_px;
		logic [FIELD_W-1:0] top_px;
		logic [FIELD_W-1:0] right_px;
		logic [FIELD_W-1:0] bottom_px;
		logic               last_in_frame;
	} box_in_t;

	typedef struct packed {
		logic             keep;
		logic [POS_W-1:0] kept_position;
		logic             overflow;
		logic             frame_done;
	} result_t;

	// Status from the IoU compare pipeline back to the sequencer
	typedef struct packed {
		logic busy;
		logic hit;
	} pipe_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AREA,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

// ===== hdl/gibs_ram.sv =====
module gibs_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/gibs_iou_pipe.sv =====
module gibs_iou_pipe #(
	parameter int CW = gibs_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_valid,
	input  logic [4*CW-1:0]            q_box,
	input  logic [4*CW-1:0]            cur_box,
	input  logic [2*CW-1:0]            area_p,
	input  logic [gibs_pkg::THR_W-1:0] thr,
	output gibs_pkg::pipe_status_t     status
);
	import gibs_pkg::*;

	localparam int AW_ = 2 * CW;          // area width
	localparam int UW  = AW_ + 1;         // union width
	localparam int PW  = THR_W + UW;      // product / compare width

	logic [CW-1:0] pl, pt, pr, pb, ql, qt, qr, qb;
	logic [CW-1:0] il, it, ir, ib;
	logic [CW-1:0] iw, ih, qw, qh;

	logic          v_s1_q, v_s2_q, v_s3_q, v_s4_q;
	logic [CW-1:0] iw_s1, ih_s1, qw_s1, qh_s1;
	logic [AW_-1:0] inter_s2, areaq_s2;
	logic [AW_-1:0] inter_s3;
	logic [UW-1:0]  uni_s3;
	logic [AW_-1:0] inter_s4;
	logic [PW-1:0]  prod_s4;
	logic [PW-1:0]  lhs;

	assign {pl, pt, pr, pb} = cur_box;
	assign {ql, qt, qr, qb} = q_box;

	// Intersection corners; an empty overlap gives zero width
	always_comb begin
		il = (pl > ql) ? pl : ql;
		it = (pt > qt) ? pt : qt;
		ir = (pr < qr) ? pr : qr;
		ib = (pb < qb) ? pb : qb;
		iw = (ir > il) ? ir - il : '0;
		ih = (ib > it) ? ib - it : '0;
		qw = (qr > ql) ? qr - ql : '0;
		qh = (qb > qt) ? qb - qt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
		end else begin
			v_s1_q <= rd_valid;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			v_s4_q <= v_s3_q;
		end
	end

	always_ff @(posedge clk) begin
		iw_s1    <= iw;
		ih_s1    <= ih;
		qw_s1    <= qw;
		qh_s1    <= qh;
		inter_s2 <= AW_'(iw_s1) * AW_'(ih_s1);
		areaq_s2 <= AW_'(qw_s1) * AW_'(qh_s1);
		inter_s3 <= inter_s2;
		uni_s3   <= UW'(area_p) + UW'(areaq_s2) - UW'(inter_s2);
		inter_s4 <= inter_s3;
		prod_s4  <= PW'(thr) * PW'(uni_s3);
	end

	// inter * 65536 against thr * union
	assign lhs = PW'({inter_s4, 16'h0000});

	assign status.busy = v_s1_q | v_s2_q | v_s3_q | v_s4_q;
	assign status.hit  = v_s4_q & (lhs > prod_s4);

endmodule

// ===== hdl/greedy_iou_box_suppression_unit.sv =====
// Channel   Dir  Handshake              Word
// in        in   in_valid / in_ready    box_in_t: box edges, last_in_frame
// out       out  out_valid / out_ready  result_t: keep, kept_position, overflow, frame_done
// cfg       in   cfg_we                 cfg_wdata: IoU threshold over 65536
//
// One box per scan: the kept-box RAM read port feeds one IoU compare per cycle
// through the RAM read register and the IoU compare pipeline; the next box is
// taken in the cycle after the result is loaded at the earliest.
// in_ready is high only in idle; a finished word waits in the output register
// while the next box is taken. arst_n clears the sequencer, the kept count and
// the threshold (to 0.5); the kept-box RAM is not cleared, entries at or above
// the kept count are never read.
module greedy_iou_box_suppression_unit #(
	parameter int MAX_KEPT   = gibs_pkg::MAX_KEPT_DEF,
	parameter int COORD_BITS = gibs_pkg::COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  gibs_pkg::box_in_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output gibs_pkg::result_t          out_data,
	input  logic                       cfg_we,
	input  logic [gibs_pkg::THR_W-1:0] cfg_wdata
);
	import gibs_pkg::*;

	localparam int CW   = COORD_BITS;
	localparam int AW   = $clog2(MAX_KEPT);       // RAM address width
	localparam int CNTW = $clog2(MAX_KEPT + 1);   // kept count, can hold MAX_KEPT
	localparam int BW   = 4 * CW;                 // one stored box

	state_t state_q, state_d;

	logic [THR_W-1:0] thr_q;
	logic [CNTW-1:0]  count_q;   // boxes kept in this frame
	logic [CNTW-1:0]  idx_q;     // scan pointer
	logic             hit_q;     // sticky: some kept box overlaps too much
	logic             v_rd_q;    // RAM read data valid
	logic             out_valid_q;
	result_t          out_data_q;

	// current box and its area
	logic [CW-1:0]    cl_q, ct_q, cr_q, cb_q;
	logic             last_q;
	logic [2*CW-1:0]  area_p_q;
	logic [CW-1:0]    cw_w, ch_w;

	logic             rd_en, wr_en, out_load, accept;
	logic             survive, full;
	logic [BW-1:0]    cur_box, rdata;
	pipe_status_t     pst;

	assign accept  = in_valid & in_ready;
	assign cur_box = {cl_q, ct_q, cr_q, cb_q};
	assign survive = ~hit_q;
	assign full    = (count_q == CNTW'(MAX_KEPT));

	assign cw_w = (cr_q > cl_q) ? cr_q - cl_q : '0;
	assign ch_w = (cb_q > ct_q) ? cb_q - ct_q : '0;

	// Sequencer: area of the new box, scan the kept list, drain, decide
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		out_load = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_AREA;
				end
			end
			ST_AREA: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (idx_q < count_q) begin
					rd_en = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_rd_q && !pst.busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold here while the previous word is still unclaimed
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					wr_en    = survive & ~full;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			v_rd_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_rd_q  <= rd_en;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (accept) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (accept) begin
				hit_q <= 1'b0;
			end else if (pst.hit) begin
				hit_q <= 1'b1;
			end
			if (out_load) begin
				if (last_q) begin
					count_q <= '0;
				end else if (wr_en) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cl_q   <= CW'(in_data.left_px);
			ct_q   <= CW'(in_data.top_px);
			cr_q   <= CW'(in_data.right_px);
			cb_q   <= CW'(in_data.bottom_px);
			last_q <= in_data.last_in_frame;
		end
		if (state_q == ST_AREA) begin
			area_p_q <= (2*CW)'(cw_w) * (2*CW)'(ch_w);
		end
		if (out_load) begin
			out_data_q.keep          <= survive & ~full;
			out_data_q.kept_position <= (survive & ~full) ? POS_W'(count_q) : '0;
			out_data_q.overflow      <= survive & full;
			out_data_q.frame_done    <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	gibs_ram #(
		.WIDTH(BW),
		.DEPTH(MAX_KEPT)
	) u_kept_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(count_q[AW-1:0]),
		.wdata(cur_box),
		.re   (rd_en),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	gibs_iou_pipe #(
		.CW(CW)
	) u_iou_pipe (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_valid(v_rd_q),
		.q_box   (rdata),
		.cur_box (cur_box),
		.area_p  (area_p_q),
		.thr     (thr_q),
		.status  (pst)
	);

endmodule

// ===== hdl/gibs_checker.sv =====
module gibs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input gibs_pkg::result_t          out_data
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// a box is either stored or dropped for lack of room, never both
	a_keep_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.keep && out_data.overflow))
		else $error("keep and overflow both set");

	// position only means something for a kept box
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.keep |-> out_data.kept_position == '0)
		else $error("nonzero position on a dropped box");

	// in_ready drops after a box is taken: no back-to-back boxes
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("new box taken while a scan is running");

endmodule

bind greedy_iou_box_suppression_unit gibs_checker u_gibs_checker (.*);

// ===== tb/sv/greedy_iou_box_suppression_unit_tb.sv =====
module greedy_iou_box_suppression_unit_tb;
	import gibs_pkg::*;

	localparam int MAX_KEPT   = MAX_KEPT_DEF;
	localparam int COORD_MAX  = (1 << COORD_BITS_DEF) - 1;
	localparam int DRAIN_WAIT = MAX_KEPT + 40;   // scan of a full store plus pipeline

	// Box edges as kept in the store
	typedef struct packed {
		logic [FIELD_W-1:0] l;
		logic [FIELD_W-1:0] t;
		logic [FIELD_W-1:0] r;
		logic [FIELD_W-1:0] b;
	} edges_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	box_in_t          in_data;
	logic             out_valid;
	logic             out_ready;
	result_t          out_data;
	logic             cfg_we;
	logic [THR_W-1:0] cfg_wdata;

	// Suppression state mirrored on the testbench side
	edges_t           kept_list [MAX_KEPT];
	int unsigned      kept_n = 0;
	logic [THR_W-1:0] iou_thr = THR_RESET;

	result_t verdicts_due[$];   // one expected word per accepted box, oldest first

	// Pacing knobs
	bit tx_gaps_on = 1'b1;
	bit rx_gaps_on = 1'b1;
	int rx_wait    = 0;
	int hold_req   = 0;
	logic hold_off = 1'b0;

	// Tallies
	int mismatches   = 0;
	int boxes_sent   = 0;
	int n_kept       = 0;
	int n_suppressed = 0;
	int n_overflow   = 0;
	int n_frames     = 0;
	int thr_writes   = 0;
	int longest_hold = 0;

	greedy_iou_box_suppression_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Length of one side, zero when the box is inverted or flat
	function automatic logic [63:0] extent(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
		return (hi > lo) ? 64'(hi - lo) : 64'd0;
	endfunction

	// True when the IoU of the two boxes is strictly above the threshold.
	// Cross-multiplied: inter * 2^16 > thr * union, all exact integers.
	function automatic logic overlaps_past_thr(edges_t p, edges_t q);
		logic [FIELD_W-1:0] il, it, ir, ib;
		logic [63:0]        inter, area_p, area_q, uni;
		il = (p.l > q.l) ? p.l : q.l;
		it = (p.t > q.t) ? p.t : q.t;
		ir = (p.r < q.r) ? p.r : q.r;
		ib = (p.b < q.b) ? p.b : q.b;
		if (il >= ir || it >= ib)
			return 1'b0;   // disjoint or touching: IoU is zero
		inter  = 64'(ir - il) * 64'(ib - it);
		area_p = extent(p.l, p.r) * extent(p.t, p.b);
		area_q = extent(q.l, q.r) * extent(q.t, q.b);
		uni    = area_p + area_q - inter;
		return (inter << 16) > (64'(iou_thr) * uni);
	endfunction

	// Runs one box through greedy suppression, updates the kept list and
	// returns the word the block must produce for it.
	function automatic result_t suppress_box(box_in_t bx);
		edges_t  cur;
		result_t res;
		logic    survives;
		cur.l    = bx.left_px;
		cur.t    = bx.top_px;
		cur.r    = bx.right_px;
		cur.b    = bx.bottom_px;
		res      = '0;
		survives = 1'b1;
		for (int i = 0; i < kept_n; i++) begin
			if (overlaps_past_thr(cur, kept_list[i])) begin
				survives = 1'b0;
				break;
			end
		end
		if (survives) begin
			if (kept_n < MAX_KEPT) begin
				kept_list[kept_n] = cur;
				res.keep          = 1'b1;
				res.kept_position = POS_W'(kept_n);
				kept_n++;
			end else begin
				res.overflow = 1'b1;   // would survive, no room left
			end
		end
		if (bx.last_in_frame)
			kept_n = 0;
		res.frame_done = bx.last_in_frame;
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Every word taken from the block is matched against the oldest
	// pending expectation; a word with nothing pending is an error too.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch("word with no box pending, keep", out_data.keep, 0);
			end else begin
				want = verdicts_due.pop_front();
				if (out_data.keep !== want.keep)
					report_mismatch("keep", out_data.keep, want.keep);
				if (out_data.kept_position !== want.kept_position)
					report_mismatch("kept_position", out_data.kept_position,
						want.kept_position);
				if (out_data.overflow !== want.overflow)
					report_mismatch("overflow", out_data.overflow, want.overflow);
				if (out_data.frame_done !== want.frame_done)
					report_mismatch("frame_done", out_data.frame_done, want.frame_done);
				if (want.keep)
					n_kept++;
				else if (want.overflow)
					n_overflow++;
				else
					n_suppressed++;
				if (want.frame_done)
					n_frames++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pacing
	// ------------------------------------------------------------------

	// Idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Long receiver hold-off, counted here so the sender keeps pushing
	initial begin : hold_off_counter
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_off <= 1'b1;
				if (hold_req > longest_hold)
					longest_hold = hold_req;
				repeat (hold_req) @(posedge clk);
				hold_off <= 1'b0;
				hold_req = 0;
			end
		end
	end

	// Receiver: random stalls after a taken word and now and then while idle
	always @(posedge clk) begin : sink_pacing
		int n;
		if (!arst_n || hold_off) begin
			out_ready <= 1'b0;
		end else if (rx_wait != 0) begin
			out_ready <= 1'b0;
			rx_wait   <= rx_wait - 1;
		end else if (rx_gaps_on && ((out_valid && out_ready) || $urandom_range(0, 15) == 0)) begin
			n = idle_len();
			out_ready <= (n == 0);
			rx_wait   <= (n == 0) ? 0 : n - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Sending and configuration
	// ------------------------------------------------------------------

	function automatic int clamp_coord(int v);
		if (v < 0)
			return 0;
		if (v > COORD_MAX)
			return COORD_MAX;
		return v;
	endfunction

	function automatic box_in_t make_box(int l, int t, int r, int b, bit last);
		box_in_t bx;
		bx.left_px       = FIELD_W'(clamp_coord(l));
		bx.top_px        = FIELD_W'(clamp_coord(t));
		bx.right_px      = FIELD_W'(clamp_coord(r));
		bx.bottom_px     = FIELD_W'(clamp_coord(b));
		bx.last_in_frame = last;
		return bx;
	endfunction

	// Offers one box and holds it until taken. Valid stays up when the
	// next box follows with no gap, so it is never dropped and raised
	// in the same step.
	task automatic send_box(input box_in_t bx);
		int gap;
		gap = tx_gaps_on ? idle_len() : 0;
		if (gap != 0) begin
			if (in_valid)
				in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= bx;
		do @(posedge clk); while (!in_ready);
		verdicts_due.push_back(suppress_box(bx));
		boxes_sent++;
	endtask

	// Stops offering and waits until every pending word has come back
	task automatic drain();
		if (in_valid)
			in_valid <= 1'b0;
		do @(posedge clk); while (verdicts_due.size() != 0);
	endtask

	// Threshold writes only land while the block is idle
	task automatic write_threshold(input logic [THR_W-1:0] thr);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_we    <= 1'b0;
		iou_thr = thr;
		thr_writes++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Zero-size and full-image boxes at the default 0.5 threshold
	task automatic test_edges_and_degenerate();
		write_threshold(THR_RESET);
		send_box(make_box(0, 0, 0, 0, 0));                            // flat: kept
		send_box(make_box(0, 0, COORD_MAX, COORD_MAX, 0));            // full image: kept
		send_box(make_box(0, 0, COORD_MAX, COORD_MAX, 0));            // identical: gone
		send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0));
		send_box(make_box(COORD_MAX, COORD_MAX, 0, 0, 0));            // inverted: kept
		send_box(make_box(0, 0, COORD_MAX, COORD_MAX, 1));            // gone, ends frame
	endtask

	// Shared edges do not overlap; small overlap stays under threshold
	task automatic test_disjoint_and_touching();
		send_box(make_box(0, 0, 10, 10, 0));
		send_box(make_box(10, 0, 20, 10, 0));
		send_box(make_box(0, 10, 10, 20, 0));
		send_box(make_box(4000, 4000, 4095, 4095, 0));
		send_box(make_box(5, 5, 15, 15, 1));   // IoU 25/175 vs the first box
	endtask

	// IoU exactly at threshold keeps; anything above suppresses
	task automatic test_threshold_ties();
		// 2/4 at 0.5: tie, kept; third box is 2/3 against the second
		send_box(make_box(100, 100, 102, 102, 0));
		send_box(make_box(100, 100, 102, 101, 0));
		send_box(make_box(100, 100, 103, 101, 1));
		// 1/4 at 0.25: tie, kept; 2/4 then suppressed
		write_threshold(16'd16384);
		send_box(make_box(0, 0, 4, 1, 0));
		send_box(make_box(0, 0, 1, 1, 0));
		send_box(make_box(0, 0, 2, 1, 1));
		// zero threshold: a single shared pixel suppresses
		write_threshold(16'd0);
		send_box(make_box(0, 0, 100, 100, 0));
		send_box(make_box(99, 99, 200, 200, 0));
		send_box(make_box(100, 100, 200, 200, 1));
		// top threshold: only an identical box is suppressed
		write_threshold(16'hFFFF);
		send_box(make_box(0, 0, COORD_MAX, COORD_MAX, 0));
		send_box(make_box(0, 0, COORD_MAX, COORD_MAX - 1, 0));
		send_box(make_box(0, 0, COORD_MAX, COORD_MAX, 1));
	endtask

	// Fill the store, then overflow, suppression on a full store, and a
	// fresh frame starting again at position zero
	task automatic test_store_full();
		int stride;
		stride = (COORD_MAX + 1) / MAX_KEPT;
		write_threshold(THR_RESET);
		for (int i = 0; i < MAX_KEPT; i++)
			send_box(make_box(i * stride, 100, i * stride + stride / 2, 108, 0));
		send_box(make_box(0, 200, 8, 208, 0));                  // survives, no room
		send_box(make_box(0, 100, stride / 2, 108, 0));         // matches entry 0
		send_box(make_box(COORD_MAX, COORD_MAX, 0, 0, 1));      // flat, overflow, last
		send_box(make_box(0, 100, stride / 2, 108, 1));         // new frame: slot 0
	endtask

	// Receiver stops for a long time while the sender keeps offering, so
	// the output register and the scan both fill and in_ready drops
	task automatic test_output_backpressure();
		drain();
		tx_gaps_on = 1'b0;
		hold_req   = 400;
		for (int i = 0; i < 8; i++)
			send_box(make_box(i * 300, i * 200, i * 300 + 50, i * 200 + 40, i == 7));
		tx_gaps_on = 1'b1;
	endtask

	// Frames of clustered boxes with random content: most boxes jitter
	// around a few centers so suppression really happens, some are tiny
	// scattered boxes, flat boxes, raw noise or repeats. A few long
	// frames of scattered boxes run the store into overflow.
	task automatic test_random_frames(input int n_items, input logic [THR_W-1:0] thr);
		int      sent, flen, kind, ncl, c, j, l, t, w, h;
		int      cx[4], cy[4], cw[4], ch[4];
		box_in_t bx;
		box_in_t seen[$];
		write_threshold(thr);
		sent = 0;
		while (sent < n_items) begin
			flen = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 90) : $urandom_range(1, 30);
			ncl  = $urandom_range(1, 4);
			for (c = 0; c < 4; c++) begin
				cx[c] = $urandom_range(0, COORD_MAX);
				cy[c] = $urandom_range(0, COORD_MAX);
				cw[c] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, COORD_MAX)
					: $urandom_range(2, 300);
				ch[c] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, COORD_MAX)
					: $urandom_range(2, 300);
			end
			seen.delete();
			for (int k = 0; k < flen; k++) begin
				kind = $urandom_range(0, 99);
				if (flen > MAX_KEPT && kind < 85)
					kind = 70;
				if (kind < 65) begin
					c  = $urandom_range(0, ncl - 1);
					j  = cw[c] / 4 + 1;
					l  = cx[c] - cw[c] / 2 + $urandom_range(0, j) - j / 2;
					w  = cw[c] + $urandom_range(0, j) - j / 2;
					j  = ch[c] / 4 + 1;
					t  = cy[c] - ch[c] / 2 + $urandom_range(0, j) - j / 2;
					h  = ch[c] + $urandom_range(0, j) - j / 2;
					bx = make_box(l, t, l + w, t + h, 0);
				end else if (kind < 80 || (kind >= 95 && seen.size() == 0)) begin
					l  = $urandom_range(0, COORD_MAX);
					t  = $urandom_range(0, COORD_MAX);
					bx = make_box(l, t, l + $urandom_range(1, 16), t + $urandom_range(1, 16), 0);
				end else if (kind < 88) begin
					l  = $urandom_range(0, COORD_MAX);
					bx = make_box(l, $urandom_range(0, COORD_MAX), $urandom_range(0, l),
						$urandom_range(0, COORD_MAX), 0);
				end else if (kind < 95) begin
					bx = make_box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
						$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 0);
				end else begin
					bx = seen[$urandom_range(0, seen.size() - 1)];   // exact repeat
				end
				// Frame end mostly in place; sometimes missing or early
				if (k == flen - 1)
					bx.last_in_frame = ($urandom_range(0, 19) != 0);
				else
					bx.last_in_frame = ($urandom_range(0, 49) == 0);
				send_box(bx);
				seen.push_back(bx);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edges_and_degenerate();
		test_disjoint_and_touching();
		test_threshold_ties();
		test_store_full();
		test_output_backpressure();

		test_random_frames(240, THR_W'($urandom));
		test_random_frames(200, 16'd0);
		test_random_frames(200, 16'hFFFF);
		// a stretch with no idling on either side
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		test_random_frames(220, THR_W'($urandom_range(16384, 49152)));
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		test_random_frames(200, 16'd1);
		test_random_frames(240, THR_RESET);

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Checked %0d boxes over %0d frames: %0d kept, %0d suppressed, %0d overflow.",
			boxes_sent, n_frames, n_kept, n_suppressed, n_overflow);
		$display("%0d threshold writes from 0 to 65535; longest output hold %0d cycles.",
			thr_writes, longest_hold);
		if (mismatches == 0 && verdicts_due.size() == 0) begin
			$display("** greedy_iou_box_suppression_unit: PASSED **");
		end else begin
			$display("** greedy_iou_box_suppression_unit: FAILED **");
		end
		$finish;
	end

	// Several times the slowest legal run: every box scanning a full store
	// with the longest gaps on both sides
	initial begin
		#20000000;
		$display("Timed out with %0d words pending.", verdicts_due.size());
		$display("** greedy_iou_box_suppression_unit: FAILED **");
		$finish;
	end

endmodule

// ===== greedy_iou_box_suppression_unit.f =====
hdl/gibs_pkg.sv
hdl/gibs_ram.sv
hdl/gibs_iou_pipe.sv
hdl/greedy_iou_box_suppression_unit.sv
hdl/gibs_checker.sv
tb/sv/greedy_iou_box_suppression_unit_tb.sv
